[design/ordwr_pkg.sv]
package ordwr_pkg;

  localparam int DEF_MAX_RULES       = 64;
  localparam int DEF_NAME_INDEX_BITS = 8;
  localparam int DEF_MASK_BITS       = 32;

  localparam int NAME_IN_BITS = 8;
  localparam int LINE_BITS    = 24;
  localparam int PID_BITS     = 22;
  localparam int MASK_IN_BITS = 32;
  localparam int POS_BITS     = 6;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [NAME_IN_BITS-1:0] prog_index;
    logic [NAME_IN_BITS-1:0] module_index;
    logic [NAME_IN_BITS-1:0] file_index;
    logic [NAME_IN_BITS-1:0] function_index;
    logic [LINE_BITS-1:0]    line_number;
    logic [PID_BITS-1:0]     process_id;
    logic [MASK_IN_BITS-1:0] set_bits;
    logic [MASK_IN_BITS-1:0] clear_bits;
  } in_item_t;

  typedef struct packed {
    logic [MASK_IN_BITS-1:0] result_mask;
    logic [POS_BITS-1:0]     rule_position;
    logic                    status;
  } out_item_t;

endpackage

[design/ordered_wildcard_rule_mask_top.sv]
// ordered wildcard rule mask
// keeps an ordered table of up to MAX_RULES rules in one synchronous memory
// input channel (in_valid / in_stall / in_data): an add item appends a rule,
// a query item walks the stored rules oldest first and builds a mask
// output channel (out_valid / out_stall / out_data): one result item per input
// an add answers its stored position, or status full when the table is full
// a query answers the mask; zero-valued rule keys match any query value
// an add moves from idle to the finish state, which loads the output register once it is free
// a query first walks the table (skipped with an empty table); the walk
// reads one rule per cycle through the memory's single read port
// one item is in work at a time; in_stall is high from acceptance until its
// result has moved into the output register
// the output register lets the next item enter while a result waits
// a stalled result holds out_data steady; the walk result waits internally
// reset empties the table (rule count to zero) and drops any pending result
module ordered_wildcard_rule_mask_top import ordwr_pkg::*; #(
  parameter int MAX_RULES       = DEF_MAX_RULES,
  parameter int NAME_INDEX_BITS = DEF_NAME_INDEX_BITS,
  parameter int MASK_BITS       = DEF_MASK_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int NB = NAME_INDEX_BITS;
  localparam int MB = MASK_BITS;
  localparam int KW = 4 * NB;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        idx_r;
  logic                 rdv_r;
  logic [MB-1:0]        acc_r;
  logic [MB-1:0]        acc_nxt;
  logic [KW-1:0]        qkeys_r;
  logic [LINE_BITS-1:0] qline_r;
  logic [PID_BITS-1:0]  qpid_r;
  out_item_t            res_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [NB+NAME_IN_BITS-1:0] prog_ext, mod_ext, file_ext, func_ext;
  logic [MB+MASK_IN_BITS-1:0] set_ext, clr_ext;
  logic [MB+MASK_IN_BITS-1:0] acc_ext;
  logic [CW+POS_BITS-1:0]     pos_ext;
  logic [KW-1:0]              in_keys;
  logic                       full;
  logic                       wr_en;
  logic                       hit;
  logic [MB-1:0]              rd_set;
  logic [MB-1:0]              rd_clr;

  assign prog_ext = {{NB{1'b0}}, in_data.prog_index};
  assign mod_ext  = {{NB{1'b0}}, in_data.module_index};
  assign file_ext = {{NB{1'b0}}, in_data.file_index};
  assign func_ext = {{NB{1'b0}}, in_data.function_index};
  assign in_keys  = {func_ext[NB-1:0], file_ext[NB-1:0], mod_ext[NB-1:0], prog_ext[NB-1:0]};
  assign set_ext  = {{MB{1'b0}}, in_data.set_bits};
  assign clr_ext  = {{MB{1'b0}}, in_data.clear_bits};
  assign pos_ext  = {{POS_BITS{1'b0}}, count_r};

  assign full     = (count_r == CW'(MAX_RULES));
  assign wr_en    = (state_r == S_IDLE) && in_valid && (in_data.opcode == OP_ADD) && !full;
  assign acc_nxt  = (rdv_r && hit) ? ((acc_r & ~rd_clr) | rd_set) : acc_r;
  assign acc_ext  = {{MASK_IN_BITS{1'b0}}, acc_nxt};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ordwr_table #(
    .MAX_RULES       (MAX_RULES),
    .NAME_INDEX_BITS (NAME_INDEX_BITS),
    .MASK_BITS       (MASK_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_keys (in_keys),
    .wr_line (in_data.line_number),
    .wr_pid  (in_data.process_id),
    .wr_set  (set_ext[MB-1:0]),
    .wr_clr  (clr_ext[MB-1:0]),
    .rd_addr (idx_r[AW-1:0]),
    .q_keys  (qkeys_r),
    .q_line  (qline_r),
    .q_pid   (qpid_r),
    .hit     (hit),
    .rd_set  (rd_set),
    .rd_clr  (rd_clr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == OP_ADD) begin
              res_r.result_mask <= '0;
              if (full) begin
                res_r.rule_position <= '0;
                res_r.status        <= STATUS_FULL;
              end else begin
                res_r.rule_position <= pos_ext[POS_BITS-1:0];
                res_r.status        <= STATUS_OK;
                count_r             <= count_r + 1'b1;
              end
              state_r <= S_FIN;
            end else begin
              qkeys_r             <= in_keys;
              qline_r             <= in_data.line_number;
              qpid_r              <= in_data.process_id;
              acc_r               <= '0;
              idx_r               <= '0;
              rdv_r               <= 1'b0;
              res_r.result_mask   <= '0;
              res_r.rule_position <= '0;
              res_r.status        <= STATUS_OK;
              state_r             <= (count_r == '0) ? S_FIN : S_WALK;
            end
          end
        end
        S_WALK: begin
          acc_r <= acc_nxt;
          if (idx_r != count_r) begin
            idx_r <= idx_r + 1'b1;
            rdv_r <= 1'b1;
          end else begin
            rdv_r             <= 1'b0;
            res_r.result_mask <= acc_ext[MASK_IN_BITS-1:0];
            state_r           <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r       <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/ordwr_table.sv]
module ordwr_table import ordwr_pkg::*; #(
  parameter int MAX_RULES       = DEF_MAX_RULES,
  parameter int NAME_INDEX_BITS = DEF_NAME_INDEX_BITS,
  parameter int MASK_BITS       = DEF_MASK_BITS,
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  localparam int KW = 4 * NAME_INDEX_BITS
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KW-1:0]        wr_keys,
  input  logic [LINE_BITS-1:0] wr_line,
  input  logic [PID_BITS-1:0]  wr_pid,
  input  logic [MASK_BITS-1:0] wr_set,
  input  logic [MASK_BITS-1:0] wr_clr,
  input  logic [AW-1:0]        rd_addr,
  input  logic [KW-1:0]        q_keys,
  input  logic [LINE_BITS-1:0] q_line,
  input  logic [PID_BITS-1:0]  q_pid,
  output logic                 hit,
  output logic [MASK_BITS-1:0] rd_set,
  output logic [MASK_BITS-1:0] rd_clr
);

  localparam int NB      = NAME_INDEX_BITS;
  localparam int LINE_LO = KW;
  localparam int PID_LO  = LINE_LO + LINE_BITS;
  localparam int SET_LO  = PID_LO + PID_BITS;
  localparam int CLR_LO  = SET_LO + MASK_BITS;
  localparam int EW      = CLR_LO + MASK_BITS;

  logic [EW-1:0] mem [MAX_RULES];
  logic [EW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_clr, wr_set, wr_pid, wr_line, wr_keys};
    end
    rd_r <= mem[rd_addr];
  end

  logic [LINE_BITS-1:0] rd_line;
  logic [PID_BITS-1:0]  rd_pid;

  assign rd_line = rd_r[PID_LO-1:LINE_LO];
  assign rd_pid  = rd_r[SET_LO-1:PID_LO];
  assign rd_set  = rd_r[CLR_LO-1:SET_LO];
  assign rd_clr  = rd_r[EW-1:CLR_LO];

  always_comb begin
    logic [NB-1:0] rf;
    logic [NB-1:0] qf;
    hit = ((rd_line == '0) || (rd_line == q_line)) &&
          ((rd_pid == '0) || (rd_pid == q_pid));
    for (int s = 0; s < 4; s++) begin
      rf = rd_r[s*NB +: NB];
      qf = q_keys[s*NB +: NB];
      if ((rf != '0) && (rf != qf)) begin
        hit = 1'b0;
      end
    end
  end

endmodule
